// ===== rtl/skms_pkg.sv =====
package skms_pkg;

    localparam int KEY_W      = 16;
    localparam int MAX_KEYS   = 4096;
    localparam int BLOCK_KEYS = 32;
    localparam int ROWS       = MAX_KEYS / BLOCK_KEYS;
    localparam int LANE_W     = $clog2(BLOCK_KEYS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BLK_W      = ROW_W + 1;
    localparam int COUNT_W    = $clog2(MAX_KEYS) + 1;
    localparam int OUT_W      = 8;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BLK_RD,
        S_BLK_CMP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic search_step;
        logic block_cmp;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query_in;
        logic search_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/skms_ctrl.sv =====
module skms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skms_pkg::sts_t sts,
    output skms_pkg::cmd_t cmd
);
    import skms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.query_in ? S_SRCH_RD : S_DONE;
                end
            end
            S_SRCH_RD:
            begin
                state_next = sts.search_done ? S_BLK_RD : S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                state_next = S_SRCH_RD;
            end
            S_BLK_RD:
            begin
                state_next = S_BLK_CMP;
            end
            S_BLK_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_SRCH_CMP:
            begin
                cmd.search_step = 1'b1;
            end
            S_BLK_CMP:
            begin
                cmd.block_cmp = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/skms_dp.sv =====
module skms_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      in_op,
    input  logic [skms_pkg::KEY_W-1:0]      in_key,
    input  skms_pkg::cmd_t                  cmd,
    output skms_pkg::sts_t                  sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [skms_pkg::OUT_W-1:0]      out_data
);
    import skms_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [KEY_W-1:0]   last_key_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BLK_W-1:0]   lo_reg;
    logic [BLK_W-1:0]   hi_reg;
    logic               found_reg;
    status_t            status_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [KEY_W-1:0]   spine_mem [ROWS];
    logic [KEY_W-1:0]   spine_rd_reg;

    logic [KEY_W-1:0]   lane_rd [BLOCK_KEYS];
    logic [BLOCK_KEYS-1:0] lane_we;

    logic [BLK_W-1:0]   blocks;
    logic [BLK_W:0]     mid_sum;
    logic [BLK_W-1:0]   mid;
    logic               is_full;
    logic               is_order_err;
    logic               append_ok;
    logic               spine_we;
    logic               row_full;
    logic               hit;

    assign blocks  = count_reg[COUNT_W-1:LANE_W];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[BLK_W:1];

    assign is_full      = (count_reg == COUNT_W'(MAX_KEYS));
    assign is_order_err = (count_reg != '0) && (in_key <= last_key_reg);
    assign append_ok    = cmd.accept && (op_t'(in_op) == OP_APPEND)
                          && !is_full && !is_order_err;
    assign spine_we     = append_ok && (count_reg[LANE_W-1:0] == {LANE_W{1'b1}});

    // Spine store: last key of every full block.
    always_ff @(posedge clk)
    begin
        if (spine_we)
        begin
            spine_mem[count_reg[LANE_W+ROW_W-1:LANE_W]] <= in_key;
        end
        spine_rd_reg <= spine_mem[mid[ROW_W-1:0]];
    end

    // Key store split into one memory per lane; a row is one block.
    for (genvar g = 0; g < BLOCK_KEYS; g++)
    begin : g_lane
        logic [KEY_W-1:0] lane_mem [ROWS];

        assign lane_we[g] = append_ok && (count_reg[LANE_W-1:0] == LANE_W'(g));

        always_ff @(posedge clk)
        begin
            if (lane_we[g])
            begin
                lane_mem[count_reg[LANE_W+ROW_W-1:LANE_W]] <= in_key;
            end
            lane_rd[g] <= lane_mem[lo_reg[ROW_W-1:0]];
        end
    end

    assign row_full = (lo_reg < blocks);

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < BLOCK_KEYS; i++)
        begin
            if ((lane_rd[i] == key_reg)
                && (row_full || (LANE_W'(i) < count_reg[LANE_W-1:0])))
            begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_key_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (op_t'(in_op) == OP_CLEAR))
            begin
                count_reg    <= '0;
                last_key_reg <= '0;
            end
            else if (append_ok)
            begin
                count_reg    <= count_reg + COUNT_W'(1);
                last_key_reg <= in_key;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg   <= in_key;
            lo_reg    <= '0;
            hi_reg    <= blocks;
            found_reg <= 1'b0;
            if (op_t'(in_op) == OP_APPEND)
            begin
                if (is_full)
                begin
                    status_reg <= ST_FULL;
                end
                else if (is_order_err)
                begin
                    status_reg <= ST_ORDER;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
        else if (cmd.search_step)
        begin
            if (spine_rd_reg < key_reg)
            begin
                lo_reg <= mid + BLK_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        else if (cmd.block_cmp)
        begin
            found_reg <= hit;
        end

        if (cmd.load_out)
        begin
            out_data_reg <= {{(OUT_W - 3){1'b0}}, status_reg, found_reg};
        end
    end

    assign sts.query_in    = (op_t'(in_op) == OP_QUERY);
    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/sorted_key_set_membership_top.sv =====
// Channel   | Direction | Signals                       | Contents
// ----------+-----------+-------------------------------+---------------------------------
// s_axis    | in        | tvalid, tready, tdata, tuser  | tdata: key; tuser: opcode
// m_axis    | out       | tvalid, tready, tdata         | tdata: found, status
//
// A clear, append or unused request skips the search and goes from acceptance to the output
// register. A query first runs a binary search over the spine, at most 128 entries:
// each binary step costs one registered spine read and one compare, then all lanes
// of a block are read. While a result waits, one more request is accepted and then
// holds until it is taken.
// rst_n clears the key count, the last key and all handshake state; the key
// and spine memories are not cleared and are only read below the key count.
module sorted_key_set_membership_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] key
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] found, [2:1] status, [7:3] zero
);
    import skms_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences the request through the spine search and
    // the block compare; it owns only the state register.
    skms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the key store, the spine, the search bounds and
    // the output register.
    skms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_axis_tuser),
        .in_key    (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== tb/sorted_key_set_membership_top_test.sv =====
`timescale 1ns / 100ps

module sorted_key_set_membership_top_test;
    import skms_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 460;
    // Ten full blocks are filled; the spacing spreads their keys over the
    // whole key range.
    localparam int FILL_KEYS = 10 * BLOCK_KEYS;
    localparam int FILL_SPAN = 65536 / FILL_KEYS;

    typedef struct {
        op_t         op;
        logic [15:0] key;
        bit          hold;  // wait for every pending result before sending
    } set_request_t;

    typedef struct packed {
        logic    found;
        status_t status;
    } set_reply_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] key
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] found, [2:1] status, [7:3] zero

    sorted_key_set_membership_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Requests waiting to be sent and the replies expected from accepted ones.
    set_request_t request_queue[$];
    set_request_t cur_req;
    set_reply_t   expected_replies[$];
    set_reply_t   want_reply;

    // Predicted contents of the set.
    logic [15:0] held_keys [MAX_KEYS];
    logic [15:0] spine_keys [ROWS];
    int          held_count = 0;
    logic [15:0] held_last = '0;

    // Keys the stimulus believes are in the set, used to aim queries.
    logic [15:0] gen_keys[$];
    int          queued_total = 0;

    int  cycle_count = 0;
    int  err_count = 0;
    int  reply_index = 0;
    logic req_accepted = 1'b0;
    logic reply_taken = 1'b0;
    int  send_wait = 0;
    int  send_calm = 0;
    int  recv_wait = 0;
    int  recv_calm = 0;

    // Draws the idle cycles before the next request or reply. Now and then a
    // stretch of zero waits is started so that back-to-back traffic occurs.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Spine-guided membership search over the predicted set: quaternary
    // descent, then binary steps, to the first full block whose last key is
    // not below the query; past the last full block the partial tail is used.
    function automatic logic search_set(logic [15:0] key);
        int   blocks, base, n, q, c, h, lo, first, len;
        logic hit;
        blocks = held_count / BLOCK_KEYS;
        base = 0;
        n = blocks;
        hit = 1'b0;
        if (blocks == 0)
        begin
            first = 0;
            len = held_count;
        end
        else
        begin
            while (n > 3)
            begin
                q = n >> 2;
                c = 0;
                if (spine_keys[base + q] < key) c++;
                if (spine_keys[base + 2 * q] < key) c++;
                if (spine_keys[base + 3 * q] < key) c++;
                base += c * q;
                n -= 3 * q;
            end
            while (n > 1)
            begin
                h = n >> 1;
                if (spine_keys[base + h] < key) base += h;
                n -= h;
            end
            lo = (spine_keys[base] < key) ? base + 1 : base;
            if (lo < blocks)
            begin
                first = lo * BLOCK_KEYS;
                len = BLOCK_KEYS;
            end
            else
            begin
                first = blocks * BLOCK_KEYS;
                len = held_count - first;
            end
        end
        for (int i = 0; i < len; i++)
            if (held_keys[first + i] == key) hit = 1'b1;
        return hit;
    endfunction

    // Applies one accepted request to the predicted set and returns its reply.
    function automatic set_reply_t predict_reply(op_t op, logic [15:0] key);
        set_reply_t r;
        r.found = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_CLEAR:
            begin
                held_count = 0;
                held_last = '0;
            end
            OP_APPEND:
            begin
                // The full check takes priority over the order check.
                if (held_count >= MAX_KEYS)
                    r.status = ST_FULL;
                else if (held_count > 0 && key <= held_last)
                    r.status = ST_ORDER;
                else
                begin
                    held_keys[held_count] = key;
                    held_count++;
                    held_last = key;
                    if (held_count % BLOCK_KEYS == 0)
                        spine_keys[held_count / BLOCK_KEYS - 1] = key;
                end
            end
            OP_QUERY:
                r.found = search_set(key);
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 100)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic push_req(input op_t op, input logic [15:0] key, input bit hold);
        set_request_t r;
        r.op = op;
        r.key = key;
        r.hold = hold;
        request_queue.push_back(r);
        queued_total++;
        if (op == OP_CLEAR)
            gen_keys.delete();
        else if (op == OP_APPEND && gen_keys.size() < MAX_KEYS
                 && (gen_keys.size() == 0 || key > gen_keys[$]))
            gen_keys.push_back(key);
    endtask

    // Queries aimed at held keys, their neighbors, the range ends and noise.
    task automatic query_mix(input int count);
        logic [15:0] key;
        int          sz;
        for (int i = 0; i < count; i++)
        begin
            sz = gen_keys.size();
            key = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    if (sz > 0) key = gen_keys[$urandom_range(0, sz - 1)];
                5, 6:
                    if (sz > 0)
                        key = gen_keys[$urandom_range(0, sz - 1)]
                              + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
                7:
                    key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:
                    ;
            endcase
            push_req(OP_QUERY, key, 1'b0);
        end
    endtask

    // Driver: requests change at the falling edge. A request stays valid
    // until it is accepted; then the next one waits its drawn idle cycles.
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = s_axis_tvalid;
        if (rst_n)
        begin
            if (req_accepted)
            begin
                next_valid = 1'b0;
                send_wait = draw_wait(send_calm);
            end
            if (!next_valid)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (request_queue.size() > 0
                         && !(request_queue[0].hold && expected_replies.size() != 0))
                begin
                    cur_req = request_queue.pop_front();
                    next_valid = 1'b1;
                    s_axis_tdata <= cur_req.key;
                    s_axis_tuser <= cur_req.op;
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // Receiver: stalls a drawn number of cycles after each taken reply.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (reply_taken)
                recv_wait = draw_wait(recv_calm);
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Rising edge: check replies against the oldest prediction, predict
    // accepted requests, and watch the cycle limit.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_key_set_membership_top test failed");
            $finish;
        end
        else
        begin
            cycle_count++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch($sformatf("reply %0d with no request pending",
                                              reply_index));
                else
                begin
                    want_reply = expected_replies.pop_front();
                    if (m_axis_tdata[0] !== want_reply.found)
                        report_mismatch($sformatf("reply %0d found %b, expected %b",
                                                  reply_index, m_axis_tdata[0],
                                                  want_reply.found));
                    if (m_axis_tdata[2:1] !== want_reply.status)
                        report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                                  reply_index, m_axis_tdata[2:1],
                                                  want_reply.status));
                    if (m_axis_tdata[7:3] !== 5'd0)
                        report_mismatch($sformatf("reply %0d padding %b not zero",
                                                  reply_index, m_axis_tdata[7:3]));
                end
                reply_index++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_replies.push_back(predict_reply(cur_req.op, cur_req.key));
            req_accepted <= s_axis_tvalid && s_axis_tready;
            reply_taken <= m_axis_tvalid && m_axis_tready;
        end
    end

    initial
    begin
        int random_start, run_len, max_step, next_key, pick;

        // Directed part: empty set, range ends, duplicates, lower keys,
        // the unused opcode and a query after clear.
        push_req(OP_QUERY, 16'h0000, 1'b0);
        push_req(OP_QUERY, 16'hFFFF, 1'b0);
        push_req(OP_APPEND, 16'hFFFF, 1'b0);
        push_req(OP_QUERY, 16'hFFFF, 1'b0);
        push_req(OP_QUERY, 16'h0000, 1'b0);
        push_req(OP_APPEND, 16'hFFFF, 1'b0);
        push_req(OP_APPEND, 16'h0000, 1'b0);
        push_req(OP_NONE, 16'hFFFF, 1'b0);
        push_req(OP_CLEAR, 16'hFFFF, 1'b0);
        push_req(OP_QUERY, 16'hFFFF, 1'b0);
        push_req(OP_APPEND, 16'h0000, 1'b0);
        push_req(OP_APPEND, 16'h0000, 1'b0);
        push_req(OP_APPEND, 16'h0001, 1'b0);
        push_req(OP_APPEND, 16'h8000, 1'b0);
        push_req(OP_QUERY, 16'h0000, 1'b0);
        push_req(OP_QUERY, 16'h0001, 1'b0);
        push_req(OP_QUERY, 16'h0002, 1'b0);
        push_req(OP_QUERY, 16'h8000, 1'b0);
        push_req(OP_QUERY, 16'h7FFF, 1'b0);
        push_req(OP_NONE, 16'h0000, 1'b0);
        push_req(OP_CLEAR, 16'h0000, 1'b0);

        // Fill ten full blocks so the spine search takes several steps, then
        // append the top key and a random key, which is always out of order.
        push_req(OP_CLEAR, 16'h5A5A, 1'b1);
        for (int i = 0; i < FILL_KEYS; i++)
            push_req(OP_APPEND, 16'(i * FILL_SPAN + $urandom_range(0, FILL_SPAN - 1)), 1'b0);
        push_req(OP_APPEND, 16'hFFFF, 1'b0);
        push_req(OP_APPEND, 16'($urandom), 1'b1);
        query_mix(80);
        push_req(OP_NONE, 16'($urandom), 1'b0);

        // Random part: runs of ascending appends with random spacing, mixed
        // with queries, rejected appends and the unused opcode.
        random_start = queued_total;
        while (queued_total - random_start < RANDOM_ITEMS)
        begin
            push_req(OP_CLEAR, 16'($urandom), $urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0: run_len = $urandom_range(0, 3);
                1: run_len = $urandom_range(BLOCK_KEYS - 1, BLOCK_KEYS + 1);
                2: run_len = $urandom_range(2 * BLOCK_KEYS - 1, 2 * BLOCK_KEYS + 1);
                3: run_len = $urandom_range(4 * BLOCK_KEYS - 1, 4 * BLOCK_KEYS + 1);
                default: run_len = $urandom_range(4, 60);
            endcase
            case ($urandom_range(0, 4))
                0: max_step = 1;
                1: max_step = 8;
                2: max_step = 100;
                3: max_step = 1000;
                default: max_step = 20000;
            endcase
            for (int j = 0; j < run_len; j++)
            begin
                pick = $urandom_range(0, 29);
                if (pick < 4)
                    query_mix(1);
                else if (pick < 6 && gen_keys.size() > 0)
                    push_req(OP_APPEND, gen_keys[$] - 16'($urandom_range(0, 3)), 1'b0);
                else if (pick == 6)
                    push_req(OP_NONE, 16'($urandom), 1'b0);
                if (gen_keys.size() == 0)
                    next_key = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 3000);
                else
                    next_key = gen_keys[$] + $urandom_range(1, max_step);
                // A key past the top wraps around and is rejected as out of order.
                push_req(OP_APPEND, 16'(next_key), 1'b0);
            end
            query_mix($urandom_range(4, 30));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (err_count == 0)
            $display("sorted_key_set_membership_top test passed");
        else
            $display("sorted_key_set_membership_top test failed");
        $finish;
    end

endmodule
